// ===== hdl/tts_pkg.sv =====
// Shared types, constants and state codes for the triangle tangent stream.
package tts_pkg;

    // Q16.16 word and derived datapath widths
    localparam int QW     = 32;
    localparam int FRAC   = 16;
    localparam int DW     = QW + 1;
    localparam int MW     = 2 * QW;
    localparam int AW     = MW + 2;
    localparam int QBITS  = 32;
    localparam int RW     = 49;
    localparam int NDELTA = 10;
    localparam int CNT_W  = $clog2(NDELTA);
    localparam int QCNT_W = $clog2(QBITS);

    // Vertex slot within a triangle
    typedef logic [1:0] t_phase;
    localparam t_phase PH_V0 = 2'd0;
    localparam t_phase PH_V1 = 2'd1;
    localparam t_phase PH_V2 = 2'd2;

    // Multiply-accumulate pairs: determinant, then one per tangent axis
    typedef logic [1:0] t_pair;
    localparam t_pair PAIR_DET = 2'd0;
    localparam t_pair PAIR_X   = 2'd1;
    localparam t_pair PAIR_Y   = 2'd2;
    localparam t_pair PAIR_Z   = 2'd3;

    typedef struct packed {
        logic signed [QW-1:0] pos_x;
        logic signed [QW-1:0] pos_y;
        logic signed [QW-1:0] pos_z;
        logic signed [QW-1:0] tex_u;
        logic signed [QW-1:0] tex_v;
    } t_vtx;

    typedef t_vtx [2:0] t_tri;

    // Sign and magnitude of one edge delta
    typedef struct packed {
        logic          sgn;
        logic [QW-1:0] mag;
    } t_sm;

    typedef struct packed {
        logic signed [QW-1:0] x;
        logic signed [QW-1:0] y;
        logic signed [QW-1:0] z;
        logic signed [QW-1:0] w;
        logic                 degraded;
        logic                 saturated;
    } t_tan;

    typedef struct packed {
        logic                 done;
        logic signed [QW-1:0] w;
        logic                 sat;
    } t_rcp_stat;

    typedef struct packed {
        logic idle;
        logic done;
    } t_core_stat;

    typedef enum logic [2:0] {
        CORE_IDLE,
        CORE_DELTA,
        CORE_MAC,
        CORE_WAIT,
        CORE_DONE
    } t_core_state;

    typedef enum logic [2:0] {
        MS_MUL_A,
        MS_ACC_A,
        MS_MUL_B,
        MS_ACC_B,
        MS_SAVE
    } t_mac_step;

    typedef enum logic [1:0] {
        RCP_IDLE,
        RCP_CHECK,
        RCP_RUN,
        RCP_DONE
    } t_rcp_state;

    // Substitute texture delta of 1.0
    localparam t_sm SM_ONE = '{sgn: 1'b0, mag: 32'h0001_0000};

    // Determinant of the substitute coordinates, -1.0 in Q32.32
    localparam logic signed [AW-1:0] DET_SUBST = {{(AW-32){1'b1}}, 32'h0};

    // Reciprocal bounds: quotient is 0 above 2^48, clips below 2^17 and at 2^17 when positive
    localparam logic [AW-1:0] RCP_LIMIT = {{(AW-49){1'b0}}, 1'b1, 48'h0};
    localparam logic [AW-1:0] RCP_SMALL = {{(AW-18){1'b0}}, 1'b1, 17'h0};
    localparam logic [RW-1:0] REM_INIT  = {{(RW-17){1'b0}}, 1'b1, 16'h0};

    localparam logic signed [QW-1:0] Q_MAX      = {1'b0, {(QW-1){1'b1}}};
    localparam logic signed [QW-1:0] Q_MIN      = {1'b1, {(QW-1){1'b0}}};
    localparam logic signed [QW-1:0] W_DEGRADED = 32'hFFFF_0000;

endpackage

// ===== hdl/tts_if.sv =====
// Valid/ready channel interfaces for vertex words and tangent words.
interface tts_vtx_if import tts_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic signed [QW-1:0] pos_x;
    logic signed [QW-1:0] pos_y;
    logic signed [QW-1:0] pos_z;
    logic signed [QW-1:0] tex_u;
    logic signed [QW-1:0] tex_v;

    modport source (output valid, output pos_x, output pos_y, output pos_z,
                    output tex_u, output tex_v, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input pos_z,
                    input tex_u, input tex_v, output ready);
endinterface

interface tts_tan_if import tts_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic signed [QW-1:0] tangent_x;
    logic signed [QW-1:0] tangent_y;
    logic signed [QW-1:0] tangent_z;
    logic signed [QW-1:0] tangent_w;
    logic                 degraded;
    logic                 saturated;

    modport source (output valid, output tangent_x, output tangent_y, output tangent_z,
                    output tangent_w, output degraded, output saturated, input ready);
    modport sink   (input valid, input tangent_x, input tangent_y, input tangent_z,
                    input tangent_w, input degraded, input saturated, output ready);
endinterface

// ===== hdl/tts_recip.sv =====
// Restoring radix-2 divider forming the saturated Q16.16 reciprocal 2^48 / det.
module tts_recip import tts_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [AW-1:0] i_det,
    output t_rcp_stat            o_stat
);

    t_rcp_state             r_state, n_state;
    logic                   r_neg;
    logic [AW-1:0]          r_mag;
    logic [RW-1:0]          r_rem;
    logic [QBITS-1:0]       r_quo;
    logic [QCNT_W-1:0]      r_cnt;
    logic signed [QW-1:0]   r_w;
    logic                   r_sat;

    logic                   too_big;
    logic                   clips;
    logic                   last_step;
    logic [RW:0]            trial;
    logic                   q_bit;
    logic [RW-1:0]          n_rem;
    logic [QBITS-1:0]       n_quo;

    // Range checks on the magnitude
    assign too_big   = r_mag > RCP_LIMIT;
    assign clips     = (r_mag < RCP_SMALL) || ((r_mag == RCP_SMALL) && !r_neg);
    assign last_step = r_cnt == QCNT_W'(QBITS - 1);

    // One trial subtraction per cycle
    always_comb begin
        trial = {1'b0, r_rem[RW-2:0], 1'b0} - {1'b0, r_mag[RW-1:0]};
        q_bit = !trial[RW];
        n_rem = q_bit ? trial[RW-1:0] : {r_rem[RW-2:0], 1'b0};
        n_quo = {r_quo[QBITS-2:0], q_bit};
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            RCP_IDLE:  if (i_start) n_state = RCP_CHECK;
            RCP_CHECK: n_state = (too_big || clips) ? RCP_DONE : RCP_RUN;
            RCP_RUN:   if (last_step) n_state = RCP_DONE;
            RCP_DONE:  if (i_start) n_state = RCP_CHECK;
            default:   n_state = RCP_IDLE;
        endcase
    end

    // Status toward the core
    always_comb begin
        o_stat.done = r_state == RCP_DONE;
        o_stat.w    = r_w;
        o_stat.sat  = r_sat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= RCP_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Load operand, classify, then iterate the quotient bits
    always_ff @(posedge i_clk) begin
        if (i_start && (r_state == RCP_IDLE || r_state == RCP_DONE)) begin
            r_neg <= i_det[AW-1];
            r_mag <= i_det[AW-1] ? AW'(-i_det) : AW'(i_det);
        end
        if (r_state == RCP_CHECK) begin
            r_rem <= REM_INIT;
            r_quo <= '0;
            r_cnt <= '0;
            if (too_big) begin
                r_w   <= '0;
                r_sat <= 1'b0;
            end else if (clips) begin
                r_w   <= r_neg ? Q_MIN : Q_MAX;
                r_sat <= 1'b1;
            end
        end
        if (r_state == RCP_RUN) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
            r_cnt <= r_cnt + QCNT_W'(1);
            if (last_step) begin
                r_w   <= r_neg ? QW'(-n_quo) : QW'(n_quo);
                r_sat <= 1'b0;
            end
        end
    end

    // Partial remainder stays below the divisor
    a_rem_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == RCP_RUN) |-> (AW'(r_rem) < r_mag))
        else $error("divider remainder not below divisor");

endmodule

// ===== hdl/tts_core.sv =====
// Sequencer with edge-delta subtractor and one shared multiply-accumulate unit.
module tts_core import tts_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic       i_precise,
    input  t_tri       i_tri,
    input  logic       i_take,
    output t_core_stat o_stat,
    output t_tan       o_res
);

    t_core_state           r_state, n_state;
    logic [CNT_W-1:0]      r_cnt;
    t_pair                 r_pair;
    t_mac_step             r_step, n_step;

    logic                  r_precise;
    t_sm                   r_dp1 [3];
    t_sm                   r_dp2 [3];
    t_sm                   r_du1, r_dv1, r_du2, r_dv2;
    logic [MW-1:0]         r_pmag;
    logic                  r_pneg;
    logic signed [AW-1:0]  r_acc;
    logic                  r_degraded;
    logic signed [QW-1:0]  r_tan [3];
    logic                  r_sat;

    logic signed [QW-1:0]  d_a, d_b;
    logic signed [DW-1:0]  d_diff, d_neg;
    t_sm                   d_sm;
    t_sm                   dv1e, dv2e, mul_a, mul_b;
    logic                  half_b;
    logic                  mul_step, acc_step, save_step;
    logic [AW-1:0]         p_ext;
    logic signed [AW-1:0]  p_val, acc_base;
    logic                  deg_now;
    logic [AW-QW-FRAC:0]   acc_hi;
    logic                  sat_flag;
    logic signed [QW-1:0]  sat_val;
    logic                  rcp_start;
    logic signed [AW-1:0]  rcp_det;
    t_rcp_stat             rcp_stat;

    tts_recip u_recip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (rcp_start),
        .i_det   (rcp_det),
        .o_stat  (rcp_stat)
    );

    // Select the operands of one edge delta
    always_comb begin
        d_a = '0;
        d_b = '0;
        case (r_cnt)
            4'd0: begin d_a = i_tri[1].pos_x; d_b = i_tri[0].pos_x; end
            4'd1: begin d_a = i_tri[1].pos_y; d_b = i_tri[0].pos_y; end
            4'd2: begin d_a = i_tri[1].pos_z; d_b = i_tri[0].pos_z; end
            4'd3: begin d_a = i_tri[2].pos_x; d_b = i_tri[0].pos_x; end
            4'd4: begin d_a = i_tri[2].pos_y; d_b = i_tri[0].pos_y; end
            4'd5: begin d_a = i_tri[2].pos_z; d_b = i_tri[0].pos_z; end
            4'd6: begin d_a = i_tri[1].tex_u; d_b = i_tri[0].tex_u; end
            4'd7: begin d_a = i_tri[1].tex_v; d_b = i_tri[0].tex_v; end
            4'd8: begin d_a = i_tri[2].tex_u; d_b = i_tri[0].tex_u; end
            4'd9: begin d_a = i_tri[2].tex_v; d_b = i_tri[0].tex_v; end
            default: begin d_a = '0; d_b = '0; end
        endcase
        d_diff   = {d_a[QW-1], d_a} - {d_b[QW-1], d_b};
        d_neg    = -d_diff;
        d_sm.sgn = d_diff[DW-1];
        d_sm.mag = d_diff[DW-1] ? d_neg[QW-1:0] : d_diff[QW-1:0];
    end

    // Pick multiplier operands for the current pair and half
    always_comb begin
        half_b = (r_step == MS_MUL_B);
        dv1e   = r_degraded ? SM_ONE : r_dv1;
        dv2e   = r_degraded ? SM_ONE : r_dv2;
        mul_a  = r_du1;
        mul_b  = r_dv2;
        case (r_pair)
            PAIR_DET: begin
                mul_a = half_b ? r_dv1 : r_du1;
                mul_b = half_b ? r_du2 : r_dv2;
            end
            PAIR_X: begin
                mul_a = half_b ? r_dp2[0] : r_dp1[0];
                mul_b = half_b ? dv1e : dv2e;
            end
            PAIR_Y: begin
                mul_a = half_b ? r_dp2[1] : r_dp1[1];
                mul_b = half_b ? dv1e : dv2e;
            end
            PAIR_Z: begin
                mul_a = half_b ? r_dp2[2] : r_dp1[2];
                mul_b = half_b ? dv1e : dv2e;
            end
            default: begin
                mul_a = r_du1;
                mul_b = r_dv2;
            end
        endcase
    end

    // Signed accumulate of the registered product
    always_comb begin
        p_ext    = {{(AW-MW){1'b0}}, r_pmag};
        p_val    = r_pneg ? -p_ext : p_ext;
        acc_base = (r_step == MS_ACC_A) ? '0 : r_acc;
    end

    // Floor shift by the fraction width, then clip to Q16.16
    always_comb begin
        acc_hi   = r_acc[AW-1:QW+FRAC-1];
        sat_flag = !((acc_hi == '0) || (acc_hi == '1));
        if (sat_flag) begin
            sat_val = r_acc[AW-1] ? Q_MIN : Q_MAX;
        end else begin
            sat_val = r_acc[QW+FRAC-1:FRAC];
        end
    end

    // Advance the micro-step within a pair
    always_comb begin
        unique case (r_step)
            MS_MUL_A: n_step = MS_ACC_A;
            MS_ACC_A: n_step = MS_MUL_B;
            MS_MUL_B: n_step = MS_ACC_B;
            MS_ACC_B: n_step = MS_SAVE;
            MS_SAVE:  n_step = MS_MUL_A;
            default:  n_step = MS_MUL_A;
        endcase
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            CORE_IDLE:  if (i_start) n_state = CORE_DELTA;
            CORE_DELTA: if (r_cnt == CNT_W'(NDELTA - 1)) n_state = CORE_MAC;
            CORE_MAC:   if (r_step == MS_SAVE && r_pair == PAIR_Z) n_state = CORE_WAIT;
            CORE_WAIT:  if (rcp_stat.done) n_state = CORE_DONE;
            CORE_DONE:  if (i_take) n_state = CORE_IDLE;
            default:    n_state = CORE_IDLE;
        endcase
    end

    // Outputs and step strobes
    always_comb begin
        mul_step    = (r_state == CORE_MAC) && (r_step == MS_MUL_A || r_step == MS_MUL_B);
        acc_step    = (r_state == CORE_MAC) && (r_step == MS_ACC_A || r_step == MS_ACC_B);
        save_step   = (r_state == CORE_MAC) && (r_step == MS_SAVE);
        deg_now     = !r_precise || (r_acc == '0);
        rcp_start   = save_step && (r_pair == PAIR_DET);
        rcp_det     = deg_now ? DET_SUBST : r_acc;
        o_stat.idle = r_state == CORE_IDLE;
        o_stat.done = r_state == CORE_DONE;
        o_res.x         = r_tan[0];
        o_res.y         = r_tan[1];
        o_res.z         = r_tan[2];
        o_res.w         = rcp_stat.w;
        o_res.degraded  = r_degraded;
        o_res.saturated = r_sat || rcp_stat.sat;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CORE_IDLE;
            r_cnt   <= '0;
            r_pair  <= PAIR_DET;
            r_step  <= MS_MUL_A;
        end else begin
            r_state <= n_state;
            case (r_state)
                CORE_IDLE: begin
                    r_cnt  <= '0;
                    r_pair <= PAIR_DET;
                    r_step <= MS_MUL_A;
                end
                CORE_DELTA: r_cnt <= r_cnt + CNT_W'(1);
                CORE_MAC: begin
                    r_step <= n_step;
                    if (r_step == MS_SAVE) begin
                        r_pair <= r_pair + 2'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (r_state == CORE_IDLE && i_start) begin
            r_precise <= i_precise;
            r_sat     <= 1'b0;
        end
        if (r_state == CORE_DELTA) begin
            case (r_cnt)
                4'd0: r_dp1[0] <= d_sm;
                4'd1: r_dp1[1] <= d_sm;
                4'd2: r_dp1[2] <= d_sm;
                4'd3: r_dp2[0] <= d_sm;
                4'd4: r_dp2[1] <= d_sm;
                4'd5: r_dp2[2] <= d_sm;
                4'd6: r_du1    <= d_sm;
                4'd7: r_dv1    <= d_sm;
                4'd8: r_du2    <= d_sm;
                4'd9: r_dv2    <= d_sm;
                default: ;
            endcase
        end
        if (mul_step) begin
            r_pmag <= MW'(mul_a.mag) * MW'(mul_b.mag);
            r_pneg <= mul_a.sgn ^ mul_b.sgn ^ half_b;
        end
        if (acc_step) begin
            r_acc <= acc_base + p_val;
        end
        if (save_step) begin
            case (r_pair)
                PAIR_DET: r_degraded <= deg_now;
                PAIR_X: begin
                    r_tan[0] <= sat_val;
                    r_sat    <= r_sat || sat_flag;
                end
                PAIR_Y: begin
                    r_tan[1] <= sat_val;
                    r_sat    <= r_sat || sat_flag;
                end
                PAIR_Z: begin
                    r_tan[2] <= sat_val;
                    r_sat    <= r_sat || sat_flag;
                end
                default: ;
            endcase
        end
    end

    // A finished word always carries a finished reciprocal
    a_done_has_recip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == CORE_DONE) |-> rcp_stat.done)
        else $error("tangent word ready before reciprocal");

    // Starting the divider drops any stale reciprocal
    a_recip_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rcp_start |=> !rcp_stat.done)
        else $error("divider kept stale result after start");

endmodule

// ===== hdl/triangle_tangent_stream.sv =====
// Top level: vertex holding, mode register, core and output word register.
// The first two vertices of a triangle are only held; the third keeps the block busy for
//   10 delta steps and 20 multiply-accumulate steps, overlapped with a check and 32 steps
//   of a restoring divider, and the tangent word then goes to the output register once it is free.
// The divider steps are skipped when the reciprocal is zero or clips. Not ready while the
//   core is busy, so the vertices of a new triangle wait until the core is through with the last.
// Reset: synchronous, active low; clears phase and output valid, sets precise mode to 1.
module triangle_tangent_stream import tts_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic           i_cfg_data,
    tts_vtx_if.sink        i_vtx,
    tts_tan_if.source      o_tan
);

    logic        r_precise;
    t_phase      r_phase, n_phase;
    t_tri        r_tri;
    t_tan        r_out;
    logic        r_out_valid;

    logic        in_acc;
    logic [1:0]  slot;
    t_vtx        in_word;
    logic        core_start;
    logic        core_take;
    t_core_stat  core_stat;
    t_tan        core_res;

    tts_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (core_start),
        .i_precise (r_precise),
        .i_tri     (r_tri),
        .i_take    (core_take),
        .o_stat    (core_stat),
        .o_res     (core_res)
    );

    // Take a vertex word only while the core is free
    assign i_vtx.ready = core_stat.idle;
    assign in_acc      = i_vtx.valid && i_vtx.ready;

    always_comb begin
        in_word.pos_x = i_vtx.pos_x;
        in_word.pos_y = i_vtx.pos_y;
        in_word.pos_z = i_vtx.pos_z;
        in_word.tex_u = i_vtx.tex_u;
        in_word.tex_v = i_vtx.tex_v;
    end

    // Decode the slot of the incoming vertex
    always_comb begin
        unique case (r_phase)
            PH_V1: begin slot = 2'd1; n_phase = PH_V2; end
            PH_V2: begin slot = 2'd2; n_phase = PH_V0; end
            default: begin slot = 2'd0; n_phase = PH_V1; end
        endcase
    end

    assign core_start = in_acc && (r_phase == PH_V2);
    assign core_take  = core_stat.done && (!r_out_valid || o_tan.ready);

    // Drive the output word
    always_comb begin
        o_tan.valid     = r_out_valid;
        o_tan.tangent_x = r_out.x;
        o_tan.tangent_y = r_out.y;
        o_tan.tangent_z = r_out.z;
        o_tan.tangent_w = r_out.w;
        o_tan.degraded  = r_out.degraded;
        o_tan.saturated = r_out.saturated;
    end

    // Control: mode register, phase, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_precise   <= 1'b1;
            r_phase     <= PH_V0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_precise <= i_cfg_data;
            end
            if (in_acc) begin
                r_phase <= n_phase;
            end
            if (core_take) begin
                r_out_valid <= 1'b1;
            end else if (o_tan.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold vertex words and the result word
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_tri[slot] <= in_word;
        end
        if (core_take) begin
            r_out <= core_res;
        end
    end

    // Substitute coordinates always give a reciprocal of -1.0
    a_degraded_w: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.degraded) |-> (r_out.w == W_DEGRADED))
        else $error("degraded tangent word with wrong w");

    // The closing vertex of a triangle launches the core
    a_third_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (r_phase == PH_V2)) |=> !core_stat.idle)
        else $error("third vertex did not start the core");

endmodule

// ===== tb/triangle_tangent_stream_tb.sv =====
// Self-checking bench for the triangle tangent stream: directed table, then random triangles.
module triangle_tangent_stream_tb;
    import tts_pkg::*;

    // Wide enough to hold every Q32.32 product and sum exactly
    typedef logic signed [79:0] t_wide;

    typedef enum logic { ROW_VTX, ROW_MODE } t_row_kind;

    typedef struct {
        t_row_kind kind;
        t_vtx      vtx;
        logic      mode;
        logic      has_exp;
        t_tan      exp_tan;
    } t_row;

    typedef struct {
        logic has_exp;
        t_tan exp_tan;
    } t_hint;

    localparam logic signed [QW-1:0] Q_ONE     = 32'sh0001_0000;
    localparam logic signed [QW-1:0] Q_NEG_ONE = 32'shFFFF_0000;
    localparam t_wide WIDE_MAX       = t_wide'(Q_MAX);
    localparam t_wide WIDE_MIN       = t_wide'(Q_MIN);
    localparam t_wide RCP_NUM        = t_wide'(1) <<< 48;
    localparam t_wide RCP_NEG_LIMIT  = t_wide'(1) <<< 31;
    localparam int    RANDOM_VERTICES = 1400;
    localparam int    SETTLE_CYCLES   = 64;
    localparam int    WATCHDOG_LIMIT  = 4000;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_data;

    tts_vtx_if vtx_bus ();
    tts_tan_if tan_bus ();

    triangle_tangent_stream DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_vtx      (vtx_bus),
        .o_tan      (tan_bus)
    );

    always #2 i_clk = ~i_clk;

    // Predictor state: held vertices, slot in the triangle, mode copy
    t_vtx   held_v0 = '0;
    t_vtx   held_v1 = '0;
    t_phase tri_phase = PH_V0;
    logic   mode_copy = 1'b1;
    t_tan   tangent_expect [$];
    t_hint  vertex_hints [$];
    t_vtx   pending [$];

    // Monitor scratch and run statistics
    t_vtx  seen_vtx;
    t_tan  next_tangent;
    t_hint row_hint;
    logic  moved;
    int    idle_cycles = 0;
    int    errors = 0;
    int    vertices_in = 0;
    int    tangents_out = 0;
    int    degraded_out = 0;
    int    saturated_out = 0;
    int    mode_writes = 0;

    // Sender burst control
    int   burst_left = 0;
    logic steady_phase = 1'b0;

    // Receiver stall pattern
    logic [31:0] ready_pat = '1;
    int          pattern_age = 0;

    // Tangent of one triangle from its three vertices and the mode in force
    function automatic t_tan tangent_of(input t_vtx a, input t_vtx b, input t_vtx c,
                                        input logic precise);
        t_wide dp1 [3];
        t_wide dp2 [3];
        t_wide du1, dv1, du2, dv2, det, acc, mag, quo;
        logic signed [QW-1:0] axis [3];
        t_tan  r;
        dp1[0] = t_wide'($signed(b.pos_x)) - t_wide'($signed(a.pos_x));
        dp1[1] = t_wide'($signed(b.pos_y)) - t_wide'($signed(a.pos_y));
        dp1[2] = t_wide'($signed(b.pos_z)) - t_wide'($signed(a.pos_z));
        dp2[0] = t_wide'($signed(c.pos_x)) - t_wide'($signed(a.pos_x));
        dp2[1] = t_wide'($signed(c.pos_y)) - t_wide'($signed(a.pos_y));
        dp2[2] = t_wide'($signed(c.pos_z)) - t_wide'($signed(a.pos_z));
        du1 = t_wide'($signed(b.tex_u)) - t_wide'($signed(a.tex_u));
        dv1 = t_wide'($signed(b.tex_v)) - t_wide'($signed(a.tex_v));
        du2 = t_wide'($signed(c.tex_u)) - t_wide'($signed(a.tex_u));
        dv2 = t_wide'($signed(c.tex_v)) - t_wide'($signed(a.tex_v));
        det = du1 * dv2 - dv1 * du2;
        r.saturated = 1'b0;
        r.degraded  = !precise || (det == 0);
        // Fall back to the substitute coordinates (0,0), (0,1), (1,1)
        if (r.degraded) begin
            du1 = 0;
            dv1 = t_wide'(Q_ONE);
            du2 = t_wide'(Q_ONE);
            dv2 = t_wide'(Q_ONE);
            det = du1 * dv2 - dv1 * du2;
        end
        // Floor to Q16.16, then clip each axis
        for (int k = 0; k < 3; k++) begin
            acc = (dp1[k] * dv2 - dp2[k] * dv1) >>> FRAC;
            if (acc > WIDE_MAX) begin
                axis[k] = Q_MAX;
                r.saturated = 1'b1;
            end else if (acc < WIDE_MIN) begin
                axis[k] = Q_MIN;
                r.saturated = 1'b1;
            end else begin
                axis[k] = acc[QW-1:0];
            end
        end
        r.x = axis[0];
        r.y = axis[1];
        r.z = axis[2];
        // Reciprocal: truncate toward zero, zero past 2^48, clip to range
        mag = (det < 0) ? -det : det;
        quo = (mag > RCP_NUM) ? t_wide'(0) : RCP_NUM / mag;
        if (det > 0) begin
            if (quo > WIDE_MAX) begin
                r.w = Q_MAX;
                r.saturated = 1'b1;
            end else begin
                r.w = quo[QW-1:0];
            end
        end else if (quo > RCP_NEG_LIMIT) begin
            r.w = Q_MIN;
            r.saturated = 1'b1;
        end else begin
            acc = -quo;
            r.w = acc[QW-1:0];
        end
        return r;
    endfunction

    function automatic logic [31:0] mesh_q();
        return $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
    endfunction

    function automatic logic [31:0] pick_edge_q();
        case ($urandom_range(0, 7))
            0: return Q_MIN;
            1: return Q_MAX;
            2: return '0;
            3: return '1;
            4: return 32'h1;
            5: return Q_ONE;
            6: return Q_NEG_ONE;
            default: return $urandom();
        endcase
    endfunction

    // Queue the three vertices of one random triangle
    function automatic void queue_triangle();
        t_vtx        tv [3];
        logic [31:0] bu, bv, du, dv;
        int          style;
        style = $urandom_range(0, 99);
        for (int k = 0; k < 3; k++) begin
            tv[k].pos_x = $urandom();
            tv[k].pos_y = $urandom();
            tv[k].pos_z = $urandom();
            tv[k].tex_u = $urandom();
            tv[k].tex_v = $urandom();
        end
        if (style < 35) begin
            // mesh-like: small positions, texture in [0, 1]
            for (int k = 0; k < 3; k++) begin
                tv[k].pos_x = mesh_q();
                tv[k].pos_y = mesh_q();
                tv[k].pos_z = mesh_q();
                tv[k].tex_u = $urandom_range(0, Q_ONE);
                tv[k].tex_v = $urandom_range(0, Q_ONE);
            end
        end else if (style < 70 && style >= 55) begin
            // zero determinant: equal or collinear texture coordinates
            bu = mesh_q();
            bv = mesh_q();
            du = ($urandom_range(0, 3) == 0) ? '0 :
                 $urandom_range(0, 32'h2000_0000) - 32'h1000_0000;
            dv = ($urandom_range(0, 3) == 0) ? '0 :
                 $urandom_range(0, 32'h2000_0000) - 32'h1000_0000;
            for (int k = 0; k < 3; k++) begin
                tv[k].tex_u = bu + k * du;
                tv[k].tex_v = bv + k * dv;
            end
        end else if (style >= 70 && style < 85) begin
            for (int k = 0; k < 3; k++) begin
                tv[k].pos_x = pick_edge_q();
                tv[k].pos_y = pick_edge_q();
                tv[k].pos_z = pick_edge_q();
                tv[k].tex_u = pick_edge_q();
                tv[k].tex_v = pick_edge_q();
            end
        end else if (style >= 85) begin
            // determinant near the reciprocal's zero and clip boundaries
            case ($urandom_range(0, 4))
                0:       begin du = 32'h0100_0000; dv = 32'h0100_0000; end
                1:       begin du = 32'h0100_0001; dv = 32'h0100_0000; end
                2:       begin du = 32'h00FF_FFFF; dv = 32'h0100_0000; end
                3:       begin du = $urandom_range(1, 3); dv = Q_ONE; end
                default: begin du = Q_ONE; dv = Q_ONE; end
            endcase
            if ($urandom_range(0, 1) == 1) du = -du;
            if ($urandom_range(0, 1) == 1) dv = -dv;
            bu = mesh_q();
            bv = mesh_q();
            tv[0].tex_u = bu;
            tv[0].tex_v = bv;
            tv[1].tex_u = bu + du;
            tv[1].tex_v = bv;
            tv[2].tex_u = bu;
            tv[2].tex_v = bv + dv;
            for (int k = 0; k < 3; k++) begin
                tv[k].pos_x = ($urandom_range(0, 1) == 1) ? pick_edge_q() : mesh_q();
                tv[k].pos_y = mesh_q();
                tv[k].pos_z = pick_edge_q();
            end
        end
        for (int k = 0; k < 3; k++)
            pending.push_back(tv[k]);
    endfunction

    function automatic t_row vrow(input t_vtx v);
        return '{kind: ROW_VTX, vtx: v, mode: 1'b0, has_exp: 1'b0, exp_tan: '0};
    endfunction

    function automatic t_row erow(input t_vtx v, input t_tan e);
        return '{kind: ROW_VTX, vtx: v, mode: 1'b0, has_exp: 1'b1, exp_tan: e};
    endfunction

    function automatic t_row mrow(input logic m);
        return '{kind: ROW_MODE, vtx: '0, mode: m, has_exp: 1'b0, exp_tan: '0};
    endfunction

    task automatic check_field(input string field, input logic signed [QW-1:0] want,
                               input logic signed [QW-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            errors++;
        end
    endtask

    // Drive one vertex word, with burst gaps, and hold it until accepted
    task automatic send_vertex(input t_vtx v, input logic has_exp, input t_tan exp_tan);
        int    gap;
        t_hint h;
        h.has_exp = has_exp;
        h.exp_tan = exp_tan;
        vertex_hints.push_back(h);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            gap = 0;
            if (!steady_phase) begin
                case ($urandom_range(0, 9))
                    0, 1, 2: gap = 0;
                    8:       gap = $urandom_range(7, 20);
                    9:       gap = $urandom_range(30, 70);
                    default: gap = $urandom_range(1, 6);
                endcase
            end
            if (gap != 0) begin
                vtx_bus.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        vtx_bus.valid <= 1'b1;
        vtx_bus.pos_x <= v.pos_x;
        vtx_bus.pos_y <= v.pos_y;
        vtx_bus.pos_z <= v.pos_z;
        vtx_bus.tex_u <= v.tex_u;
        vtx_bus.tex_v <= v.tex_v;
        @(posedge i_clk);
        while (!vtx_bus.ready) @(posedge i_clk);
    endtask

    // Wait until every tangent has come out, then let the core drain
    task automatic settle();
        repeat (2) @(posedge i_clk);
        while (tangent_expect.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic settle_and_write(input logic m);
        vtx_bus.valid <= 1'b0;
        settle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= m;
        @(posedge i_clk);
        i_cfg_we  <= 1'b0;
        mode_copy  = m;
        mode_writes++;
        burst_left = 0;
    endtask

    // Receiver: stall on a rotating pattern, reshuffled now and then
    always @(posedge i_clk) begin
        if (pattern_age == 0) begin
            pattern_age = $urandom_range(50, 300);
            case ($urandom_range(0, 3))
                0:       ready_pat = '1;
                1:       ready_pat = $urandom() | 32'h1;
                2:       ready_pat = 32'h1 << $urandom_range(0, 31);
                default: ready_pat = ($urandom() & $urandom()) | 32'h1;
            endcase
        end
        pattern_age--;
        tan_bus.ready <= ready_pat[0];
        ready_pat = {ready_pat[0], ready_pat[31:1]};
    end

    // Monitor: check tangent words, predict on vertex words, watch for a hang
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            moved = 1'b0;
            if (tan_bus.valid && tan_bus.ready) begin
                moved = 1'b1;
                tangents_out++;
                if (tan_bus.degraded) degraded_out++;
                if (tan_bus.saturated) saturated_out++;
                if (tangent_expect.size() == 0) begin
                    $error("tangent word with nothing pending");
                    errors++;
                end else begin
                    next_tangent = tangent_expect.pop_front();
                    check_field("tangent_x", next_tangent.x, tan_bus.tangent_x);
                    check_field("tangent_y", next_tangent.y, tan_bus.tangent_y);
                    check_field("tangent_z", next_tangent.z, tan_bus.tangent_z);
                    check_field("tangent_w", next_tangent.w, tan_bus.tangent_w);
                    check_field("degraded", 32'(next_tangent.degraded), 32'(tan_bus.degraded));
                    check_field("saturated", 32'(next_tangent.saturated),
                                32'(tan_bus.saturated));
                end
            end
            if (vtx_bus.valid && vtx_bus.ready) begin
                moved = 1'b1;
                vertices_in++;
                seen_vtx = '{pos_x: vtx_bus.pos_x, pos_y: vtx_bus.pos_y, pos_z: vtx_bus.pos_z,
                             tex_u: vtx_bus.tex_u, tex_v: vtx_bus.tex_v};
                row_hint = vertex_hints.pop_front();
                case (tri_phase)
                    PH_V1: begin
                        held_v1   = seen_vtx;
                        tri_phase = PH_V2;
                    end
                    PH_V2: begin
                        next_tangent = row_hint.has_exp ? row_hint.exp_tan :
                                       tangent_of(held_v0, held_v1, seen_vtx, mode_copy);
                        tangent_expect.push_back(next_tangent);
                        tri_phase = PH_V0;
                    end
                    default: begin
                        held_v0   = seen_vtx;
                        tri_phase = PH_V1;
                    end
                endcase
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $error("no word moved for %0d cycles", idle_cycles);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin
        t_row script [$];
        int   sent;
        int   phase;
        int   phase_len;

        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_data    = 1'b0;
        vtx_bus.valid = 1'b0;
        vtx_bus.pos_x = '0;
        vtx_bus.pos_y = '0;
        vtx_bus.pos_z = '0;
        vtx_bus.tex_u = '0;
        vtx_bus.tex_v = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table; expectations typed in where they are plain to see
        // all zero: zero determinant, substitute coordinates
        script.push_back(vrow(t_vtx'{0, 0, 0, 0, 0}));
        script.push_back(vrow(t_vtx'{0, 0, 0, 0, 0}));
        script.push_back(erow(t_vtx'{0, 0, 0, 0, 0}, t_tan'{0, 0, 0, Q_NEG_ONE, 1, 0}));
        // unit triangle: tangent along x, w of 1.0
        script.push_back(vrow(t_vtx'{0, 0, 0, 0, 0}));
        script.push_back(vrow(t_vtx'{Q_ONE, 0, 0, Q_ONE, 0}));
        script.push_back(erow(t_vtx'{0, Q_ONE, 0, 0, Q_ONE},
                              t_tan'{Q_ONE, 0, 0, Q_ONE, 0, 0}));
        // full-range spans: axes clip high, reciprocal underflows to zero
        script.push_back(vrow(t_vtx'{Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN}));
        script.push_back(vrow(t_vtx'{Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MIN}));
        script.push_back(erow(t_vtx'{Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MAX},
                              t_tan'{Q_MAX, Q_MAX, Q_MAX, 0, 0, 1}));
        // same spans reversed in position: axes clip low
        script.push_back(vrow(t_vtx'{Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN}));
        script.push_back(vrow(t_vtx'{Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MIN}));
        script.push_back(erow(t_vtx'{Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MAX},
                              t_tan'{Q_MIN, Q_MIN, Q_MIN, 0, 0, 1}));
        // smallest positive determinant: reciprocal clips high
        script.push_back(vrow(t_vtx'{0, 0, 0, 0, 0}));
        script.push_back(vrow(t_vtx'{0, 0, 0, 1, 0}));
        script.push_back(erow(t_vtx'{0, 0, 0, 0, 1}, t_tan'{0, 0, 0, Q_MAX, 0, 1}));
        // determinant of -2^17: reciprocal lands exactly on the minimum
        script.push_back(vrow(t_vtx'{0, 0, 0, 0, 0}));
        script.push_back(vrow(t_vtx'{-1, 0, 0, -2, 0}));
        script.push_back(erow(t_vtx'{0, 0, 0, 0, Q_ONE}, t_tan'{-1, 0, 0, Q_MIN, 0, 0}));
        // precise mode off: unit triangle degrades to dp1 - dp2
        script.push_back(mrow(1'b0));
        script.push_back(vrow(t_vtx'{0, 0, 0, 0, 0}));
        script.push_back(vrow(t_vtx'{Q_ONE, 0, 0, Q_ONE, 0}));
        script.push_back(erow(t_vtx'{0, Q_ONE, 0, 0, Q_ONE},
                              t_tan'{Q_ONE, -Q_ONE, 0, Q_NEG_ONE, 1, 0}));
        // mode turned back on between the second and third vertex
        script.push_back(vrow(t_vtx'{0, 0, 0, 0, 0}));
        script.push_back(vrow(t_vtx'{Q_ONE, 0, 0, Q_ONE, 0}));
        script.push_back(mrow(1'b1));
        script.push_back(vrow(t_vtx'{0, Q_ONE, Q_ONE, 0, Q_ONE}));

        foreach (script[n]) begin
            if (script[n].kind == ROW_MODE)
                settle_and_write(script[n].mode);
            else
                send_vertex(script[n].vtx, script[n].has_exp, script[n].exp_tan);
        end

        // Random phases; lengths that split triangles put mode writes mid-triangle
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_VERTICES) begin
            steady_phase = ($urandom_range(0, 3) == 0);
            phase_len    = $urandom_range(140, 200);
            for (int k = 0; k < phase_len && sent < RANDOM_VERTICES; k++) begin
                if (pending.size() == 0) queue_triangle();
                send_vertex(pending.pop_front(), 1'b0, '0);
                sent++;
            end
            phase++;
            settle_and_write((phase % 3 == 1) ? 1'b0 : 1'b1);
        end
        settle();

        if (tangent_expect.size() != 0) begin
            $error("%0d tangent words never came out", tangent_expect.size());
            errors++;
        end
        $display("Accepted %0d vertex words (%0d from the table), checked %0d tangents.",
                 vertices_in, script.size() - 2, tangents_out);
        $display("%0d came out degraded and %0d saturated; precise mode written %0d times.",
                 degraded_out, saturated_out, mode_writes);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
